FILE: rtl/core/pei_pkg.sv
// Shared types, codes and fixed-point helpers for the particle Euler integrator.
// Used by pei_lane, pei_ctrl and particle_euler_integrator; depends on nothing.
package pei_pkg;

  // Item action codes
  typedef enum logic [2:0] {
    ACT_INTEGRATE = 3'd0,
    ACT_ADD_FORCE = 3'd1,
    ACT_CLR_FORCE = 3'd2,
    ACT_LOAD_POS  = 3'd3,
    ACT_LOAD_VEL  = 3'd4
  } act_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_ACCEL_X   = 3'd0;
  localparam logic [2:0] CFG_ACCEL_Y   = 3'd1;
  localparam logic [2:0] CFG_ACCEL_Z   = 3'd2;
  localparam logic [2:0] CFG_INV_MASS  = 3'd3;
  localparam logic [2:0] CFG_TIME_STEP = 3'd4;
  localparam logic [2:0] CFG_DAMPING   = 3'd5;

  localparam logic [31:0] INV_MASS_RST  = 32'd65536;
  localparam logic [15:0] TIME_STEP_RST = 16'd1092;
  localparam logic [16:0] DAMPING_RST   = 17'd65536;

  // Steps of one integration pass through a lane's shared multiplier
  typedef enum logic [2:0] {
    STEP_MUL_VDT = 3'd0,
    STEP_ADD_POS = 3'd1,
    STEP_ACC     = 3'd2,
    STEP_MUL_ADT = 3'd3,
    STEP_ADD_VEL = 3'd4,
    STEP_MUL_DMP = 3'd5,
    STEP_DAMP    = 3'd6
  } step_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_CALC = 2'd2,
    ST_POST = 2'd3
  } state_t;

  // Controls broadcast from the sequencer to every lane
  typedef struct packed {
    logic  load_pos;
    logic  load_vel;
    logic  add_force;
    logic  clr_force;
    logic  step_en;
    step_t step;
  } lane_ctl_t;

  // Clamp a 49-bit signed value to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic [48:0] x);
    logic fits;
    fits = (&x[48:31]) || !(|x[48:31]);
    if (fits) begin
      return x[31:0];
    end
    return x[48] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

endpackage

FILE: rtl/core/particle_euler_integrator.sv
// Top level of the particle Euler integrator: configuration registers,
// operand capture, three axis lanes and the merged output register.
// Depends on pei_pkg, pei_lane and pei_ctrl.

// One particle, three axes, signed Q16.16. Each input transaction carries an
// action (integrate, add force, clear force, load position, load velocity)
// and a 3-axis operand; each produces exactly one output transaction with the
// position and velocity after the action. The block takes one transaction at
// a time: in_stall is high from acceptance until the result has moved into
// the output register. Add force, clear force, the loads and unused action
// codes go straight from the action to the post. Integrate runs the steps:
// each axis lane owns one 32x33 multiplier and uses it four times in a
// dependent chain (v*dt, force*inverse_mass, accel*dt, v1*damping), with the
// product registered and then added and saturated in the next cycle.
// Integrate with inverse_mass or time_step equal to zero changes nothing and
// skips the steps. The output register holds a finished result while
// out_stall is high, and a new transaction is accepted meanwhile; its result
// waits in the lanes until the output register frees. Configuration writes
// (cfg_ready is always high) take effect at the next edge, so issue them only
// while no transaction is in flight; indexes beyond the register list are
// dropped.
module particle_euler_integrator (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [31:0] value_x,
  input  logic [31:0] value_y,
  input  logic [31:0] value_z,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pos_out_x,
  output logic [31:0] pos_out_y,
  output logic [31:0] pos_out_z,
  output logic [31:0] vel_out_x,
  output logic [31:0] vel_out_y,
  output logic [31:0] vel_out_z
);

  // Configuration registers
  logic [31:0] accel_x;
  logic [31:0] accel_y;
  logic [31:0] accel_z;
  logic [31:0] inv_mass;
  logic [15:0] time_step;
  logic [16:0] damping;

  // Captured transaction
  logic [2:0]  act;
  logic [31:0] val_x;
  logic [31:0] val_y;
  logic [31:0] val_z;

  logic               in_accept;
  logic               out_free;
  logic               busy;
  logic               post;
  logic               skip;
  pei_pkg::lane_ctl_t ctl;

  logic [31:0] pos_x, pos_y, pos_z;
  logic [31:0] vel_x, vel_y, vel_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_x   <= 32'd0;
      accel_y   <= 32'd0;
      accel_z   <= 32'd0;
      inv_mass  <= pei_pkg::INV_MASS_RST;
      time_step <= pei_pkg::TIME_STEP_RST;
      damping   <= pei_pkg::DAMPING_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pei_pkg::CFG_ACCEL_X:   accel_x   <= cfg_data;
        pei_pkg::CFG_ACCEL_Y:   accel_y   <= cfg_data;
        pei_pkg::CFG_ACCEL_Z:   accel_z   <= cfg_data;
        pei_pkg::CFG_INV_MASS:  inv_mass  <= cfg_data;
        pei_pkg::CFG_TIME_STEP: time_step <= cfg_data[15:0];
        pei_pkg::CFG_DAMPING:   damping   <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Accept one transaction at a time; hold its operands for the lanes
  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      act   <= action;
      val_x <= value_x;
      val_y <= value_y;
      val_z <= value_z;
    end
  end

  // Infinite mass or a zero step leaves the state untouched
  assign skip = (inv_mass == 32'd0) || (time_step == 16'd0);

  // Output register frees when empty or when its result is taken this edge
  assign out_free = !out_valid || !out_stall;

  pei_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .action    (act),
    .skip      (skip),
    .out_free  (out_free),
    .busy      (busy),
    .post      (post),
    .ctl       (ctl)
  );

  pei_lane u_lane_x (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .value     (val_x),
    .accel     (accel_x),
    .inv_mass  (inv_mass),
    .time_step (time_step),
    .damping   (damping),
    .position  (pos_x),
    .velocity  (vel_x)
  );

  pei_lane u_lane_y (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .value     (val_y),
    .accel     (accel_y),
    .inv_mass  (inv_mass),
    .time_step (time_step),
    .damping   (damping),
    .position  (pos_y),
    .velocity  (vel_y)
  );

  pei_lane u_lane_z (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .value     (val_z),
    .accel     (accel_z),
    .inv_mass  (inv_mass),
    .time_step (time_step),
    .damping   (damping),
    .position  (pos_z),
    .velocity  (vel_z)
  );

  // Merge the three lanes into one output transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (post) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      pos_out_x <= pos_x;
      pos_out_y <= pos_y;
      pos_out_z <= pos_z;
      vel_out_x <= vel_x;
      vel_out_y <= vel_y;
      vel_out_z <= vel_z;
    end
  end

  // A result never overwrites one that is still waiting
  a_post_free: assert property (@(posedge clk) disable iff (rst)
    post |-> (!out_valid || !out_stall))
    else $error("result posted over a waiting result");

  // Lanes step only while a transaction is in flight
  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.step_en |-> in_stall)
    else $error("lane step while idle");

  // Acceptance closes the input until the result is posted
  a_accept_close: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall)
    else $error("input open right after acceptance");

  // Output valid rises only from a post
  a_valid_post: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(post))
    else $error("output valid without a post");

endmodule

FILE: rtl/core/pei_lane.sv
// One axis lane: position, velocity and force state plus a shared multiplier.
// Depends on pei_pkg for the control struct, step codes and saturation.
module pei_lane (
  input  logic                clk,
  input  logic                rst,
  input  pei_pkg::lane_ctl_t  ctl,
  input  logic [31:0]         value,
  input  logic [31:0]         accel,
  input  logic [31:0]         inv_mass,
  input  logic [15:0]         time_step,
  input  logic [16:0]         damping,
  output logic [31:0]         position,
  output logic [31:0]         velocity
);

  logic [31:0] force_sum;
  logic [31:0] tmp;
  logic [63:0] prod;

  logic signed [31:0] mul_a;
  logic        [31:0] mul_b;
  logic signed [32:0] mul_b_s;
  logic signed [65:0] prod_full;
  logic        [47:0] prod_sh;
  logic        [31:0] base;
  logic        [31:0] sum_sat;
  logic        [31:0] force_add;

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = position;
    mul_b = 32'd0;
    case (ctl.step)
      pei_pkg::STEP_MUL_VDT: begin
        mul_a = velocity;
        mul_b = {16'd0, time_step};
      end
      pei_pkg::STEP_ADD_POS: begin
        mul_a = force_sum;
        mul_b = inv_mass;
      end
      pei_pkg::STEP_MUL_ADT: begin
        mul_a = tmp;
        mul_b = {16'd0, time_step};
      end
      pei_pkg::STEP_MUL_DMP: begin
        mul_a = tmp;
        mul_b = {15'd0, damping};
      end
      default: begin
        mul_a = position;
        mul_b = 32'd0;
      end
    endcase
  end

  assign mul_b_s   = {1'b0, mul_b};
  assign prod_full = mul_a * mul_b_s;

  // Registered product, floor-shifted by 16
  assign prod_sh = prod[63:16];

  always_comb begin
    case (ctl.step)
      pei_pkg::STEP_ADD_POS: base = position;
      pei_pkg::STEP_ACC:     base = accel;
      pei_pkg::STEP_ADD_VEL: base = velocity;
      default:               base = 32'd0;
    endcase
  end

  assign sum_sat   = pei_pkg::sat32({{17{base[31]}}, base} + {prod_sh[47], prod_sh});
  assign force_add = pei_pkg::sat32({{17{force_sum[31]}}, force_sum} + {{17{value[31]}}, value});

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= 32'd0;
      velocity  <= 32'd0;
      force_sum <= 32'd0;
    end else begin
      if (ctl.load_pos) begin
        position <= value;
      end
      if (ctl.load_vel) begin
        velocity <= value;
      end
      if (ctl.add_force) begin
        force_sum <= force_add;
      end
      if (ctl.clr_force) begin
        force_sum <= 32'd0;
      end
      if (ctl.step_en) begin
        case (ctl.step)
          pei_pkg::STEP_ADD_POS: position <= sum_sat;
          pei_pkg::STEP_DAMP:    velocity <= sum_sat;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers: product and the intermediate acceleration / velocity
  always_ff @(posedge clk) begin
    if (ctl.step_en) begin
      case (ctl.step)
        pei_pkg::STEP_MUL_VDT,
        pei_pkg::STEP_ADD_POS,
        pei_pkg::STEP_MUL_ADT,
        pei_pkg::STEP_MUL_DMP: prod <= prod_full[63:0];
        pei_pkg::STEP_ACC,
        pei_pkg::STEP_ADD_VEL: tmp <= sum_sat;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/pei_ctrl.sv
// Sequencer for the integrator: takes one transaction, drives the lanes
// through the action or the integration steps, then posts the result.
// Depends on pei_pkg for state, step and action codes and the lane controls.
module pei_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_accept,
  input  logic [2:0]          action,
  input  logic                skip,
  input  logic                out_free,
  output logic                busy,
  output logic                post,
  output pei_pkg::lane_ctl_t  ctl
);

  pei_pkg::state_t state, state_next;
  pei_pkg::step_t  step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pei_pkg::ST_IDLE;
      step  <= pei_pkg::STEP_MUL_VDT;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      pei_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_next = pei_pkg::ST_EXEC;
        end
      end
      pei_pkg::ST_EXEC: begin
        step_next = pei_pkg::STEP_MUL_VDT;
        if (action == pei_pkg::ACT_INTEGRATE && !skip) begin
          state_next = pei_pkg::ST_CALC;
        end else begin
          state_next = pei_pkg::ST_POST;
        end
      end
      pei_pkg::ST_CALC: begin
        if (step == pei_pkg::STEP_DAMP) begin
          state_next = pei_pkg::ST_POST;
        end else begin
          step_next = pei_pkg::step_t'(step + 3'd1);
        end
      end
      pei_pkg::ST_POST: begin
        if (out_free) begin
          state_next = pei_pkg::ST_IDLE;
        end
      end
      default: state_next = pei_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy          = (state != pei_pkg::ST_IDLE);
    post          = 1'b0;
    ctl           = '0;
    ctl.step      = step;
    case (state)
      pei_pkg::ST_EXEC: begin
        case (action)
          pei_pkg::ACT_ADD_FORCE: ctl.add_force = 1'b1;
          pei_pkg::ACT_CLR_FORCE: ctl.clr_force = 1'b1;
          pei_pkg::ACT_LOAD_POS:  ctl.load_pos  = 1'b1;
          pei_pkg::ACT_LOAD_VEL:  ctl.load_vel  = 1'b1;
          default: ;
        endcase
      end
      pei_pkg::ST_CALC: ctl.step_en = 1'b1;
      pei_pkg::ST_POST: post = out_free;
      default: ;
    endcase
  end

endmodule
